FILE: src/command_fifo_with_opcode_extract_defines.svh
// Assertion macros for the command FIFO with opcode extract.
// Used by cfoe_dpath; relies on signals named clock and reset in scope.
`ifndef COMMAND_FIFO_WITH_OPCODE_EXTRACT_DEFINES_SVH
`define COMMAND_FIFO_WITH_OPCODE_EXTRACT_DEFINES_SVH

// same-cycle implication
`define CFOE_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("cfoe assertion failed");

// next-cycle implication
`define CFOE_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("cfoe assertion failed");

`endif

FILE: src/cfoe_pkg.sv
// Shared types, constants and the microcode ROM of the command FIFO.
// No dependencies; imported by cfoe_seq, cfoe_dpath and the top level.
`timescale 1ns / 1ps

package cfoe_pkg;

   localparam int DEPTH      = 16;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 5;
   localparam int CAP_RESET  = 16;
   localparam int WORD_W     = 16;
   localparam int OPC_W      = 4;
   localparam int OPC_LSB    = 12;
   localparam int KIND_W     = 2;
   localparam int FILL_W     = 5;
   localparam int REQ_W      = 24;
   localparam int RSP_W      = 24;
   localparam logic [WORD_W-1:0] NO_WORD = 16'hFFFF;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH, KIND_POP, KIND_EXTRACT, KIND_STATUS
   } kind_type;

   typedef enum logic [3:0] {
      STEP_IDLE, STEP_PUSH, STEP_POP_CHK, STEP_POP_RD, STEP_POP_FIN,
      STEP_EXT_INIT, STEP_SCAN_TEST, STEP_SCAN_RD, STEP_SCAN_CHK,
      STEP_SHIFT_TEST, STEP_SHIFT_RD, STEP_SHIFT_WR, STEP_EXT_FIN,
      STEP_STATUS, STEP_EMIT
   } step_type;

   typedef enum logic [3:0] {
      ACT_NOP, ACT_TAKE, ACT_PUSH, ACT_FAIL, ACT_RD_HEAD, ACT_POP_FIN,
      ACT_SCAN_INIT, ACT_RD_POS, ACT_SCAN_CHK, ACT_RD_NEXT, ACT_SHIFT_WR,
      ACT_EXT_FIN, ACT_STATUS, ACT_EMIT
   } act_type;

   typedef enum logic [2:0] {
      COND_NONE, COND_ALWAYS, COND_EMPTY, COND_SCAN_END, COND_NO_MATCH,
      COND_LAST, COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type tgt;
      logic     done;   // return to idle when no jump is taken
   } ctrl_word_type;

   typedef struct packed {
      logic empty;
      logic scan_end;
      logic no_match;
      logic last;
      logic out_busy;
   } status_type;

   function automatic ctrl_word_type ucode_rom(input step_type s);
      ctrl_word_type w;
      w = '{act: ACT_NOP, cond: COND_NONE, tgt: STEP_IDLE, done: 1'b0};
      unique case (s)
         STEP_IDLE:       w.act = ACT_TAKE;
         STEP_PUSH:       w = '{ACT_PUSH, COND_ALWAYS, STEP_EMIT, 1'b0};
         STEP_POP_CHK:    w = '{ACT_FAIL, COND_EMPTY, STEP_EMIT, 1'b0};
         STEP_POP_RD:     w.act = ACT_RD_HEAD;
         STEP_POP_FIN:    w = '{ACT_POP_FIN, COND_ALWAYS, STEP_EMIT, 1'b0};
         STEP_EXT_INIT:   w.act = ACT_SCAN_INIT;
         STEP_SCAN_TEST:  w = '{ACT_NOP, COND_SCAN_END, STEP_EMIT, 1'b0};
         STEP_SCAN_RD:    w.act = ACT_RD_POS;
         STEP_SCAN_CHK:   w = '{ACT_SCAN_CHK, COND_NO_MATCH, STEP_SCAN_TEST, 1'b0};
         STEP_SHIFT_TEST: w = '{ACT_NOP, COND_LAST, STEP_EXT_FIN, 1'b0};
         STEP_SHIFT_RD:   w.act = ACT_RD_NEXT;
         STEP_SHIFT_WR:   w = '{ACT_SHIFT_WR, COND_ALWAYS, STEP_SHIFT_TEST, 1'b0};
         STEP_EXT_FIN:    w = '{ACT_EXT_FIN, COND_ALWAYS, STEP_EMIT, 1'b0};
         STEP_STATUS:     w.act = ACT_STATUS;
         STEP_EMIT:       w = '{ACT_EMIT, COND_OUT_BUSY, STEP_EMIT, 1'b1};
         default:         w.act = ACT_NOP;
      endcase
      return w;
   endfunction

   function automatic step_type entry_step(input kind_type k);
      step_type s;
      unique case (k)
         KIND_PUSH:    s = STEP_PUSH;
         KIND_POP:     s = STEP_POP_CHK;
         KIND_EXTRACT: s = STEP_EXT_INIT;
         KIND_STATUS:  s = STEP_STATUS;
         default:      s = STEP_STATUS;
      endcase
      return s;
   endfunction

endpackage

FILE: src/command_fifo_with_opcode_extract.sv
// Top level of the command FIFO with opcode extract.
// Depends on cfoe_pkg, cfoe_seq and cfoe_dpath.
`timescale 1ns / 1ps

// Queue of 16-bit command words handled one request at a time by a small
// microcoded sequencer over a single-port-read slot memory. Each request
// returns one result. An extract scans with a test, a read and a compare
// per entry, then moves the later entries with a test, a read and a write
// each, one memory access per step. Writing capacity empties the queue; it
// is taken only while no request is in flight.
module command_fifo_with_opcode_extract
   import cfoe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // kind[1:0], push_word[17:2], target_opcode[21:18], zero[23:22]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // word_out[15:0], ok[16], is_empty[17], is_full[18], fill_level[23:19]
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_wdata
);

   ctrl_word_type ctrl;
   status_type    status;

   cfoe_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tdata[KIND_W-1:0]),
      .csr_valid  (csr_valid),
      .status     (status),
      .req_tready (req_tready),
      .csr_ready  (csr_ready),
      .ctrl       (ctrl)
   );

   cfoe_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_fire   (req_tvalid && req_tready),
      .req_tdata  (req_tdata),
      .csr_fire   (csr_valid && csr_ready),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: src/cfoe_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on cfoe_pkg.
`timescale 1ns / 1ps

module cfoe_seq
   import cfoe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic [KIND_W-1:0] req_kind,
   input  logic          csr_valid,
   input  status_type    status,
   output logic          req_tready,
   output logic          csr_ready,
   output ctrl_word_type ctrl
);

   step_type step_ff, step_in;
   logic     jump;

   assign ctrl       = ucode_rom(step_ff);
   // configuration wins over a request arriving in the same cycle
   assign csr_ready  = (ctrl.act == ACT_TAKE);
   assign req_tready = (ctrl.act == ACT_TAKE) && !csr_valid;

   always_comb begin
      unique case (ctrl.cond)
         COND_NONE:     jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_EMPTY:    jump = status.empty;
         COND_SCAN_END: jump = status.scan_end;
         COND_NO_MATCH: jump = status.no_match;
         COND_LAST:     jump = status.last;
         COND_OUT_BUSY: jump = status.out_busy;
         default:       jump = 1'b0;
      endcase
   end

   always_comb begin
      priority if (ctrl.act == ACT_TAKE) begin
         step_in = (req_tvalid && req_tready) ? entry_step(kind_type'(req_kind)) : step_ff;
      end else if (jump) begin
         step_in = ctrl.tgt;
      end else if (ctrl.done) begin
         step_in = STEP_IDLE;
      end else begin
         step_in = step_type'(step_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: src/cfoe_dpath.sv
// Datapath: slot memory, queue pointers, scan/shift registers and result register.
// Depends on cfoe_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "command_fifo_with_opcode_extract_defines.svh"

module cfoe_dpath
   import cfoe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_word_type     ctrl,
   input  logic              req_fire,
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic              csr_fire,
   input  logic [CAP_W-1:0]  csr_wdata,
   input  logic              rsp_tready,
   output status_type        status,
   output logic              rsp_tvalid,
   output logic [RSP_W-1:0]  rsp_tdata
);

   logic [WORD_W-1:0] mem [DEPTH];

   logic [IDX_W-1:0]  head_ff, tail_ff, pos_ff;
   logic [CNT_W-1:0]  count_ff, cap_ff, k_ff;
   logic [WORD_W-1:0] rdata_ff, word_ff, result_ff;
   logic [OPC_W-1:0]  target_ff;
   logic              ok_ff;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic [IDX_W-1:0]  tail_next, pos_next, rd_addr, wr_addr;
   logic              wr_en, rd_en, has_room, out_free;
   logic [CNT_W-1:0]  cap_in;

   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] n;
      n = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
      return (n >= (CNT_W+1)'(cap)) ? '0 : IDX_W'(n);
   endfunction

   function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
      logic [CNT_W-1:0] c;
      if (v == '0) begin
         c = CNT_W'(1);
      end else if (int'(v) > DEPTH) begin
         c = CNT_W'(DEPTH);
      end else begin
         c = CNT_W'(v);
      end
      return c;
   endfunction

   assign tail_next = wrap_next(tail_ff, cap_ff);
   assign pos_next  = wrap_next(pos_ff, cap_ff);
   assign has_room  = (count_ff < cap_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign cap_in    = clamp_cap(csr_wdata);

   assign status.empty    = (count_ff == '0);
   assign status.scan_end = (k_ff == count_ff);
   assign status.no_match = (rdata_ff[OPC_LSB +: OPC_W] != target_ff);
   assign status.last     = ((CNT_W+1)'(k_ff) + (CNT_W+1)'(1) == (CNT_W+1)'(count_ff));
   assign status.out_busy = !out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one write port, one registered read port
   always_comb begin
      wr_en   = ((ctrl.act == ACT_PUSH) && has_room) || (ctrl.act == ACT_SHIFT_WR);
      wr_addr = (ctrl.act == ACT_PUSH) ? tail_next : pos_ff;
      rd_en   = (ctrl.act == ACT_RD_HEAD) || (ctrl.act == ACT_RD_POS) ||
                (ctrl.act == ACT_RD_NEXT);
      unique case (ctrl.act)
         ACT_RD_HEAD: rd_addr = head_ff;
         ACT_RD_NEXT: rd_addr = pos_next;
         default:     rd_addr = pos_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= (ctrl.act == ACT_PUSH) ? word_ff : rdata_ff;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= clamp_cap(CAP_W'(CAP_RESET));
         head_ff  <= '0;
         tail_ff  <= IDX_W'(clamp_cap(CAP_W'(CAP_RESET)) - CNT_W'(1));
         count_ff <= '0;
      end else if (csr_fire) begin
         cap_ff   <= cap_in;
         head_ff  <= '0;
         tail_ff  <= IDX_W'(cap_in - CNT_W'(1));
         count_ff <= '0;
      end else begin
         unique case (ctrl.act)
            ACT_PUSH: begin
               if (has_room) begin
                  tail_ff  <= tail_next;
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            ACT_POP_FIN: begin
               head_ff  <= wrap_next(head_ff, cap_ff);
               count_ff <= count_ff - CNT_W'(1);
            end
            ACT_EXT_FIN: begin
               tail_ff  <= (tail_ff == '0) ? IDX_W'(cap_ff - CNT_W'(1))
                                           : tail_ff - IDX_W'(1);
               count_ff <= count_ff - CNT_W'(1);
            end
            default: ;
         endcase
      end
   end

   // request latch, scan registers and result
   always_ff @(posedge clock) begin
      unique case (ctrl.act)
         ACT_TAKE: begin
            if (req_fire) begin
               word_ff   <= req_tdata[KIND_W +: WORD_W];
               target_ff <= req_tdata[KIND_W+WORD_W +: OPC_W];
            end
         end
         ACT_PUSH: begin
            result_ff <= NO_WORD;
            ok_ff     <= has_room;
         end
         ACT_FAIL: begin
            result_ff <= NO_WORD;
            ok_ff     <= 1'b0;
         end
         ACT_POP_FIN: begin
            result_ff <= rdata_ff;
            ok_ff     <= 1'b1;
         end
         ACT_SCAN_INIT: begin
            pos_ff    <= head_ff;
            k_ff      <= '0;
            result_ff <= NO_WORD;
            ok_ff     <= 1'b0;
         end
         ACT_SCAN_CHK: begin
            if (!status.no_match) begin
               result_ff <= rdata_ff;
               ok_ff     <= 1'b1;
            end else begin
               pos_ff <= pos_next;
               k_ff   <= k_ff + CNT_W'(1);
            end
         end
         ACT_SHIFT_WR: begin
            pos_ff <= pos_next;
            k_ff   <= k_ff + CNT_W'(1);
         end
         ACT_STATUS: begin
            result_ff <= NO_WORD;
            ok_ff     <= 1'b1;
         end
         default: ;
      endcase
   end

   // output register; flags reflect the queue after the item's work
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((ctrl.act == ACT_EMIT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((ctrl.act == ACT_EMIT) && out_free) begin
         rsp_data_ff <= {FILL_W'(count_ff), (count_ff == cap_ff), (count_ff == '0),
                         ok_ff, result_ff};
      end
   end

   `CFOE_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= cap_ff)
   `CFOE_ASSERT_NOW(a_head_bound, 1'b1, (CNT_W+1)'(head_ff) < (CNT_W+1)'(cap_ff))
   `CFOE_ASSERT_NEXT(a_push_grows, (ctrl.act == ACT_PUSH) && has_room && !csr_fire,
                     count_ff == $past(count_ff) + CNT_W'(1))
   `CFOE_ASSERT_NOW(a_scan_in_range, ctrl.act == ACT_RD_POS, k_ff < count_ff)

endmodule
